// ===== hdl/serial_frame_crc_header_check_assert.svh =====
// Assertion macros shared by the checker of the serial frame checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SERIAL_FRAME_CRC_HEADER_CHECK_ASSERT_SVH
`define SERIAL_FRAME_CRC_HEADER_CHECK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sfc_pkg.sv =====
// Package of the serial frame CRC and header checker: types, constants, CRC step.
// No dependencies; the front, queue, back, top level and checker import it.
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

    localparam int MAX_PAYLOAD = 1024;
    // position runs up to the capped length plus the trailer
    localparam int POS_W = $clog2(MAX_PAYLOAD + 4);
    localparam int LEN_W = 11;
    localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_PAYLOAD_LEN = 2'd0;
    localparam logic [1:0] CFG_HDR_VALUE = 2'd1;
    localparam logic [1:0] CFG_HEADER_FIRST = 2'd2;
    localparam logic [1:0] CFG_HEADER_END = 2'd3;

    localparam logic [10:0] RST_PAYLOAD_LEN = 11'd64;
    localparam logic [7:0] RST_HDR_VALUE = 8'd0;
    localparam logic [9:0] RST_HEADER_FIRST = 10'd0;
    localparam logic [10:0] RST_HEADER_END = 11'd2;

    // frame status codes
    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_CRC = 2'd1;
    localparam logic [1:0] ST_HDR = 2'd2;

    // trailer byte index of the last trailer byte
    localparam logic [1:0] TK_LAST = 2'd3;

    typedef struct packed {
        logic [10:0] payload_len;
        logic [7:0]  hdr_value;
        logic [9:0]  header_first;
        logic [10:0] header_end;
    } cfg_t;

    // classified word handed from the front to the back
    typedef struct packed {
        logic [7:0] data;
        logic       is_payload;
        logic       hdr_miss;
        logic [1:0] tk;
    } sfc_item_t;

    // reflected 0xEDB88320 table for one nibble
    localparam logic [31:0] NIB_TABLE [16] = '{
        32'h0000_0000, 32'h1DB7_1064, 32'h3B6E_20C8, 32'h26D9_30AC,
        32'h76DC_4190, 32'h6B6B_51F4, 32'h4DB2_6158, 32'h5005_713C,
        32'hEDB8_8320, 32'hF00F_9344, 32'hD6D6_A3E8, 32'hCB61_B38C,
        32'h9B64_C2B0, 32'h86D3_D2D4, 32'hA00A_E278, 32'hBDBD_F21C
    };

    // two nibble steps, low nibble first, then invert
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c1;
        logic [31:0] c2;
        c1 = NIB_TABLE[crc[3:0] ^ b[3:0]] ^ (crc >> 4);
        c2 = NIB_TABLE[c1[3:0] ^ b[7:4]] ^ (c1 >> 4);
        return ~c2;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sfc_channels.sv =====
// Handshake channels of the serial frame checker: received bytes and frame status.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface sfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfc_status_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [31:0] computed_crc;

    modport source (output valid, output frame_status, output computed_crc, input ready);
    modport sink (input valid, input frame_status, input computed_crc, output ready);
endinterface

`default_nettype wire

// ===== hdl/sfc_front.sv =====
// Front of the frame checker: byte position, payload/trailer split, header compare.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfc_front
    import sfc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      in_valid,
    input  wire logic [7:0] in_byte,
    output logic           in_ready,
    input  wire logic      q_ready,
    output logic           push,
    output sfc_item_t      push_item
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             run_reg;

    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] len_cap;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] diff;
    logic             is_payload;
    logic             hdr_hit;
    logic [1:0]       tk;

    always_comb
    begin
        len_ext = CMP_W'(cfg.payload_len);
        len_cap = (len_ext > CMP_W'(MAX_PAYLOAD)) ? CMP_W'(MAX_PAYLOAD) : len_ext;
        pos_ext = CMP_W'(pos_reg);
        is_payload = pos_ext < len_cap;
        hdr_hit = (pos_ext >= CMP_W'(cfg.header_first)) && (pos_ext < CMP_W'(cfg.header_end));
        diff = pos_ext - len_cap;
        // a shrunk length may leave the position past the trailer: take it as the last byte
        tk = (diff > CMP_W'(TK_LAST)) ? TK_LAST : diff[1:0];
    end

    assign in_ready = run_reg && q_ready;
    assign push = in_valid && in_ready;

    always_comb
    begin
        push_item.data = in_byte;
        push_item.is_payload = is_payload;
        push_item.hdr_miss = is_payload && hdr_hit && (in_byte != cfg.hdr_value);
        push_item.tk = tk;
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (is_payload || (tk != TK_LAST))
                pos_next = POS_W'(pos_reg + 1'b1);
            else
                pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            run_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sfc_queue.sv =====
// Short FIFO of classified words between the front and the back.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfc_queue
    import sfc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire sfc_item_t push_item,
    output logic           q_ready,
    input  wire logic      pop,
    output logic           head_valid,
    output sfc_item_t      head_item
);

    sfc_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : QPTR_W'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : QPTR_W'(rd_ptr_reg + 1'b1);
        if (push && !pop)
            count_next = QCNT_W'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = QCNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sfc_back.sv =====
// Back of the frame checker: CRC update, trailer compare, status output register.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfc_back
    import sfc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      head_valid,
    input  wire sfc_item_t head_item,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [1:0]     out_status,
    output logic [31:0]    out_crc
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        hdr_good_reg;
    logic        hdr_good_next;
    logic        trl_good_reg;
    logic        trl_good_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_status_reg;
    logic [31:0] out_crc_reg;

    logic        head_last;
    logic [7:0]  expect_byte;
    logic        trl_ok;
    logic        emit;

    assign head_last = !head_item.is_payload && (head_item.tk == TK_LAST);
    // only the last trailer word waits for the output register
    assign pop = head_valid && (!head_last || !out_valid_reg || out_ready);
    assign emit = pop && head_last;
    assign expect_byte = crc_reg[8*head_item.tk +: 8];
    assign trl_ok = trl_good_reg && (head_item.data == expect_byte);

    always_comb
    begin
        crc_next = crc_reg;
        hdr_good_next = hdr_good_reg;
        trl_good_next = trl_good_reg;
        if (pop)
        begin
            if (head_item.is_payload)
            begin
                crc_next = crc_byte(crc_reg, head_item.data);
                hdr_good_next = hdr_good_reg && !head_item.hdr_miss;
            end
            else if (head_last)
            begin
                crc_next = CRC_INIT;
                hdr_good_next = 1'b1;
                trl_good_next = 1'b1;
            end
            else
            begin
                trl_good_next = trl_ok;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= !trl_ok ? ST_CRC : (!hdr_good_reg ? ST_HDR : ST_GOOD);
            out_crc_reg <= crc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            hdr_good_reg <= 1'b1;
            trl_good_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg <= crc_next;
            hdr_good_reg <= hdr_good_next;
            trl_good_reg <= trl_good_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_crc = out_crc_reg;

endmodule

`default_nettype wire

// ===== hdl/serial_frame_crc_header_check.sv =====
// Top level of the serial frame CRC and header checker: config registers and wiring.
// Depends on sfc_pkg, sfc_channels, sfc_front, sfc_queue and sfc_back.
//
//   channel  dir  payload                       handshake
//   rx       in   rx_byte[7:0]                  valid / ready
//   status   out  frame_status[1:0],            valid / ready
//                 computed_crc[31:0]
//   cfg      in   cfg_index[1:0], cfg_data[10:0] cfg_we, no ready
//
// One byte per cycle while the queue has room; the front classifies a word in the
// cycle it is accepted, the back folds it into the CRC after it leaves the queue.
// Status is registered after the last trailer byte has passed through the queue.
// A stalled status holds only the last trailer word; payload words keep flowing
// until the two-entry queue fills. rx ready is low in reset and until run_reg is set.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_crc_header_check
    import sfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    sfc_rx_if.sink           rx,
    sfc_status_if.source     status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      q_ready;
    logic      push;
    sfc_item_t push_item;
    logic      pop;
    logic      head_valid;
    sfc_item_t head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_len <= RST_PAYLOAD_LEN;
            cfg_reg.hdr_value <= RST_HDR_VALUE;
            cfg_reg.header_first <= RST_HEADER_FIRST;
            cfg_reg.header_end <= RST_HEADER_END;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAYLOAD_LEN:  cfg_reg.payload_len <= cfg_data;
                CFG_HDR_VALUE:    cfg_reg.hdr_value <= cfg_data[7:0];
                CFG_HEADER_FIRST: cfg_reg.header_first <= cfg_data[9:0];
                CFG_HEADER_END:   cfg_reg.header_end <= cfg_data;
                default:          ;
            endcase
        end
    end

    sfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (rx.valid),
        .in_byte   (rx.rx_byte),
        .in_ready  (rx.ready),
        .q_ready   (q_ready),
        .push      (push),
        .push_item (push_item)
    );

    sfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .q_ready    (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    sfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (status.valid),
        .out_ready  (status.ready),
        .out_status (status.frame_status),
        .out_crc    (status.computed_crc)
    );

endmodule

`default_nettype wire

// ===== hdl/sfc_checker.sv =====
// Port-level checker of the serial frame checker, bound to the top level.
// Depends on sfc_pkg and serial_frame_crc_header_check_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_frame_crc_header_check_assert.svh"

module sfc_checker
    import sfc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rx_valid,
    input wire logic        rx_ready,
    input wire logic        status_valid,
    input wire logic        status_ready,
    input wire logic [1:0]  frame_status,
    input wire logic [31:0] computed_crc
);

    logic rx_acc;

    assign rx_acc = rx_valid && rx_ready;

    `SFC_ASSERT_NEXT(a_status_hold, status_valid && !status_ready, status_valid && $stable(frame_status) && $stable(computed_crc), "status changed while stalled")
    `SFC_ASSERT_NOW(a_status_code, status_valid, frame_status == ST_GOOD || frame_status == ST_CRC || frame_status == ST_HDR, "undefined frame status")
    `SFC_ASSERT_NOW(a_status_cause, $rose(status_valid), $past(rx_acc, 2) || $past(rx_acc, 3), "status without a recent trailer byte")

endmodule

bind serial_frame_crc_header_check sfc_checker u_sfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx.valid),
    .rx_ready     (rx.ready),
    .status_valid (status.valid),
    .status_ready (status.ready),
    .frame_status (status.frame_status),
    .computed_crc (status.computed_crc)
);

`default_nettype wire
